// ----- src/fpp_pkg.sv -----
package fpp_pkg;

	// Frame limits
	localparam int unsigned MIN_FRAME = 7;
	localparam int unsigned MAX_WALK_DEF = 16;
	localparam int unsigned TOK_FIFO_DEPTH = 4;

	// Field classes held in the upper three bits of a program op
	localparam logic [2:0] CL_NONE = 3'd0;
	localparam logic [2:0] CL_U8 = 3'd1;
	localparam logic [2:0] CL_U16 = 3'd2;
	localparam logic [2:0] CL_U32 = 3'd3;
	localparam logic [2:0] CL_U64 = 3'd4;
	localparam logic [2:0] CL_STR = 3'd5;
	localparam logic [2:0] CL_D32 = 3'd6;
	localparam logic [2:0] CL_D16 = 3'd7;

	// Token kinds
	localparam logic [1:0] TK_NUM = 2'd0;
	localparam logic [1:0] TK_STR = 2'd1;
	localparam logic [1:0] TK_DATA = 2'd2;
	localparam logic [1:0] TK_STATUS = 2'd3;

	// Field codes referenced by the control logic
	localparam logic [4:0] CODE_TYPE = 5'd0;
	localparam logic [4:0] CODE_TAG = 5'd1;
	localparam logic [4:0] CODE_NWNAME = 5'd13;
	localparam logic [4:0] CODE_NWQID = 5'd15;
	localparam logic [4:0] CODE_DATA = 5'd22;

	// Status codes
	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_BAD_SIZE = 2'd1;
	localparam logic [1:0] ST_PAST_END = 2'd2;
	localparam logic [1:0] ST_WALK_LONG = 2'd3;

	localparam logic [7:0] KIND_TWALK = 8'd110;

	typedef struct packed {
		logic [1:0]  kind;
		logic [4:0]  code;
		logic [63:0] value;
		logic [1:0]  status;
		logic        last;
	} tok_t;

	// Field program per message row: {class, code}, zero ends the list
	localparam logic [7:0] PROG_TABLE [0:16][0:7] = '{
		'{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{{CL_U32, 5'd2}, {CL_STR, 5'd3}, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{{CL_U32, 5'd4}, {CL_U32, 5'd5}, {CL_STR, 5'd6}, {CL_STR, 5'd7},
			8'h00, 8'h00, 8'h00, 8'h00},
		'{{CL_U8, 5'd8}, {CL_U32, 5'd9}, {CL_U64, 5'd10}, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{{CL_STR, 5'd11}, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{{CL_U32, 5'd4}, {CL_U32, 5'd12}, {CL_U16, 5'd13}, {CL_STR, 5'd14},
			8'h00, 8'h00, 8'h00, 8'h00},
		'{{CL_U16, 5'd15}, {CL_U8, 5'd8}, {CL_U32, 5'd9}, {CL_U64, 5'd10},
			8'h00, 8'h00, 8'h00, 8'h00},
		'{{CL_U32, 5'd4}, {CL_U8, 5'd16}, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{{CL_U8, 5'd8}, {CL_U32, 5'd9}, {CL_U64, 5'd10}, {CL_U32, 5'd17},
			8'h00, 8'h00, 8'h00, 8'h00},
		'{{CL_U32, 5'd4}, {CL_STR, 5'd18}, {CL_U32, 5'd19}, {CL_U8, 5'd16},
			8'h00, 8'h00, 8'h00, 8'h00},
		'{{CL_U32, 5'd4}, {CL_U64, 5'd20}, {CL_D32, 5'd21}, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{{CL_U32, 5'd21}, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{{CL_U32, 5'd4}, {CL_U64, 5'd20}, {CL_U32, 5'd21}, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{{CL_D32, 5'd21}, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{{CL_D16, 5'd21}, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{{CL_U32, 5'd4}, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{{CL_U16, 5'd23}, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
	};

	// Number of fields in each row
	localparam logic [4:0] ROW_LEN [0:16] = '{
		5'd0, 5'd2, 5'd4, 5'd3, 5'd1, 5'd4, 5'd4, 5'd2, 5'd4,
		5'd4, 5'd3, 5'd1, 5'd3, 5'd1, 5'd1, 5'd1, 5'd1
	};

	// Map a message type byte onto its program row
	function automatic logic [4:0] row_of(input logic [7:0] kind);
		logic [4:0] r;
		case (kind) inside
			8'd100, 8'd101: r = 5'd1;
			8'd104: r = 5'd2;
			8'd105: r = 5'd3;
			8'd107: r = 5'd4;
			8'd110: r = 5'd5;
			8'd111: r = 5'd6;
			8'd112: r = 5'd7;
			8'd113, 8'd115: r = 5'd8;
			8'd114: r = 5'd9;
			8'd118: r = 5'd10;
			8'd119: r = 5'd11;
			8'd116: r = 5'd12;
			8'd117: r = 5'd13;
			8'd125: r = 5'd14;
			8'd120, 8'd122, 8'd124: r = 5'd15;
			8'd108: r = 5'd16;
			default: r = 5'd0;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] op_at(input logic [7:0] kind, input logic [4:0] step);
		logic [7:0] op;
		if (step[4:3] != 2'd0) begin
			op = 8'h00;
		end else begin
			op = PROG_TABLE[row_of(kind)][step[2:0]];
		end
		return op;
	endfunction

	function automatic logic [3:0] class_bytes(input logic [2:0] cl);
		logic [3:0] n;
		case (cl)
			CL_U8: n = 4'd1;
			CL_U16, CL_STR, CL_D16: n = 4'd2;
			CL_U64: n = 4'd8;
			default: n = 4'd4;
		endcase
		return n;
	endfunction

endpackage

// ----- src/fpp_tok_fifo.sv -----
module fpp_tok_fifo import fpp_pkg::*; #(
	parameter int unsigned DEPTH = TOK_FIFO_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr0_valid,
	input  tok_t wr0,
	input  logic wr1_valid,
	input  tok_t wr1,
	output logic room2,
	output logic out_valid,
	input  logic out_ready,
	output tok_t rd
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	tok_t          mem_q [DEPTH];
	logic [PW-1:0] wp_q, rp_q, wp1;
	logic [CW-1:0] cnt_q;
	logic          pop;
	logic [1:0]    push_n;

	function automatic logic [PW-1:0] nxt(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	assign wp1 = nxt(wp_q);
	assign pop = out_valid && out_ready;
	assign push_n = {1'b0, wr0_valid} + {1'b0, wr1_valid};
	assign out_valid = (cnt_q != '0);
	assign rd = mem_q[rp_q];
	assign room2 = (cnt_q <= CW'(DEPTH - 2));

	// Store up to two words per cycle
	always_ff @(posedge clk) begin
		if (wr0_valid) begin
			mem_q[wp_q] <= wr0;
		end
		if (wr1_valid) begin
			mem_q[wp1] <= wr1;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push_n == 2'd1) begin
				wp_q <= wp1;
			end else if (push_n == 2'd2) begin
				wp_q <= nxt(wp1);
			end
			if (pop) begin
				rp_q <= nxt(rp_q);
			end
			cnt_q <= cnt_q + CW'(push_n) - CW'(pop);
		end
	end

endmodule

// ----- src/file_protocol_frame_parser.sv -----
// Streaming 9P2000 frame parser. One frame byte is taken per cycle whenever
// the four-word token queue at the output has room for two words; the only
// thing that slows intake is a stalled consumer, since a byte can yield a
// field token and, on the last byte, the closing status token. Numeric
// fields come out as one token once their last byte arrives, string and
// payload bytes as one token each, and the final byte of a frame always
// adds a status token with is_last set, after which the parser is back at
// its reset state.
module file_protocol_frame_parser import fpp_pkg::*; #(
	parameter int unsigned MAX_WALK = MAX_WALK_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  frame_byte,
	input  logic        end_of_buffer,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  token_kind,
	output logic [4:0]  field_code,
	output logic [63:0] field_value,
	output logic [1:0]  status_code,
	output logic        is_last
);

	logic [31:0] bs_q, ds_q, run_q;
	logic [7:0]  kind_q;
	logic [4:0]  fs_q;
	logic [63:0] acc_q;
	logic [2:0]  bif_q;
	logic [6:0]  wnl_q;
	logic [1:0]  err_q;

	logic [31:0] n_bs, n_ds, n_run, rem;
	logic [7:0]  n_kind, op, adv_op;
	logic [4:0]  n_fs, fs1, adv_fs;
	logic [63:0] n_acc, accv;
	logic [2:0]  n_bif, cl;
	logic [6:0]  n_wnl, adv_wnl;
	logic [1:0]  n_err, st;
	logic        accept, f_vld;
	tok_t        f_tok, s_tok, rd;

	assign accept = in_valid && in_ready;
	assign op = op_at(kind_q, fs_q);
	assign cl = op[7:5];
	assign rem = ds_q - bs_q - 32'd1;
	assign accv = acc_q | (64'(frame_byte) << {bif_q, 3'b000});

	// Next field position after finishing one, with walk repetition
	assign fs1 = fs_q + 5'd1;
	assign adv_op = op_at(kind_q, fs1);
	always_comb begin
		adv_fs = fs1;
		adv_wnl = wnl_q;
		if (adv_op == 8'h00 && wnl_q != 7'd0) begin
			adv_wnl = wnl_q - 7'd1;
			if (wnl_q != 7'd1) begin
				adv_fs = (kind_q == KIND_TWALK) ? 5'd3 : 5'd1;
			end
		end
	end

	// Parse one frame byte
	always_comb begin
		n_bs = bs_q;
		n_ds = ds_q;
		n_run = run_q;
		n_kind = kind_q;
		n_fs = fs_q;
		n_acc = acc_q;
		n_bif = bif_q;
		n_wnl = wnl_q;
		n_err = err_q;
		f_vld = 1'b0;
		f_tok = '{kind: TK_NUM, code: CODE_TYPE, value: 64'd0, status: ST_OK, last: 1'b0};
		st = ST_OK;
		if (bs_q != 32'hFFFF_FFFF) begin
			n_bs = bs_q + 32'd1;
		end
		if (bs_q < 32'd4) begin
			n_ds[{bs_q[1:0], 3'b000} +: 8] = frame_byte;
		end else if (err_q == 2'd0 && ds_q >= 32'(MIN_FRAME) && bs_q < ds_q) begin
			if (bs_q == 32'd4) begin
				n_kind = frame_byte;
				f_vld = 1'b1;
				f_tok.code = CODE_TYPE;
				f_tok.value = 64'(frame_byte);
			end else if (bs_q == 32'd5) begin
				n_acc = 64'(frame_byte);
			end else if (bs_q == 32'd6) begin
				f_vld = 1'b1;
				f_tok.code = CODE_TAG;
				f_tok.value = acc_q | (64'(frame_byte) << 8);
				n_acc = 64'd0;
			end else if (run_q != 32'd0) begin
				f_vld = 1'b1;
				f_tok.kind = (cl == CL_STR) ? TK_STR : TK_DATA;
				f_tok.code = (cl == CL_STR) ? op[4:0] : CODE_DATA;
				f_tok.value = 64'(frame_byte);
				n_run = run_q - 32'd1;
				if (run_q == 32'd1) begin
					n_fs = adv_fs;
					n_wnl = adv_wnl;
				end
			end else if (op != 8'h00) begin
				if ({1'b0, bif_q} + 4'd1 < class_bytes(cl)) begin
					n_acc = accv;
					n_bif = bif_q + 3'd1;
				end else begin
					n_acc = 64'd0;
					n_bif = 3'd0;
					f_vld = 1'b1;
					f_tok.code = op[4:0];
					f_tok.value = accv;
					if (cl == CL_STR || cl == CL_D32 || cl == CL_D16) begin
						if (accv > {32'd0, rem}) begin
							n_err = ST_PAST_END;
						end else if (accv == 64'd0) begin
							n_fs = adv_fs;
							n_wnl = adv_wnl;
						end else begin
							n_run = accv[31:0];
						end
					end else if (op[4:0] == CODE_NWNAME || op[4:0] == CODE_NWQID) begin
						if (accv > 64'(MAX_WALK)) begin
							n_err = ST_WALK_LONG;
						end else if (accv == 64'd0) begin
							n_fs = ROW_LEN[row_of(kind_q)];
						end else begin
							n_wnl = accv[6:0];
							n_fs = fs1;
						end
					end else begin
						n_fs = adv_fs;
						n_wnl = adv_wnl;
					end
				end
			end
		end
		// Close the frame and drop all state
		if (end_of_buffer) begin
			if (n_bs < 32'(MIN_FRAME) || n_ds < 32'(MIN_FRAME) || n_ds > n_bs) begin
				st = ST_BAD_SIZE;
			end else if (n_err != 2'd0) begin
				st = n_err;
			end else if (op_at(n_kind, n_fs) != 8'h00) begin
				st = ST_PAST_END;
			end else begin
				st = ST_OK;
			end
			n_bs = '0;
			n_ds = '0;
			n_run = '0;
			n_kind = '0;
			n_fs = '0;
			n_acc = '0;
			n_bif = '0;
			n_wnl = '0;
			n_err = '0;
		end
	end

	assign s_tok = '{kind: TK_STATUS, code: 5'd0, value: 64'd0, status: st, last: 1'b1};

	// Hold parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bs_q <= '0;
			ds_q <= '0;
			run_q <= '0;
			kind_q <= '0;
			fs_q <= '0;
			acc_q <= '0;
			bif_q <= '0;
			wnl_q <= '0;
			err_q <= '0;
		end else if (accept) begin
			bs_q <= n_bs;
			ds_q <= n_ds;
			run_q <= n_run;
			kind_q <= n_kind;
			fs_q <= n_fs;
			acc_q <= n_acc;
			bif_q <= n_bif;
			wnl_q <= n_wnl;
			err_q <= n_err;
		end
	end

	// Queue tokens toward the output; status goes second when both appear
	fpp_tok_fifo #(
		.DEPTH(TOK_FIFO_DEPTH)
	) u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.wr0_valid(accept && (f_vld || end_of_buffer)),
		.wr0(f_vld ? f_tok : s_tok),
		.wr1_valid(accept && f_vld && end_of_buffer),
		.wr1(s_tok),
		.room2(in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.rd(rd)
	);

	assign token_kind = rd.kind;
	assign field_code = rd.code;
	assign field_value = rd.value;
	assign status_code = rd.status;
	assign is_last = rd.last;

	// A closed frame leaves the parser at reset
	a_eob_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && end_of_buffer |=> bs_q == 32'd0 && err_q == 2'd0 && run_q == 32'd0)
		else $error("state not cleared after end of frame");

	// A closing word always leaves a token queued
	a_eob_queued: assert property (@(posedge clk) disable iff (!arst_n)
		accept && end_of_buffer |=> out_valid)
		else $error("status token missing");

	// No field progress or run while an error is latched
	a_err_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		accept && err_q != 2'd0 |-> !f_vld)
		else $error("token produced after error");

	// Walk counter never exceeds its bound
	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(wnl_q) <= 32'(MAX_WALK))
		else $error("walk count beyond limit");

endmodule

// ----- tb/sv/file_protocol_frame_parser_tb.sv -----
`timescale 1ns / 1ps

module file_protocol_frame_parser_tb;
	import fpp_pkg::*;

	localparam int unsigned WALK_LIMIT = MAX_WALK_DEF;
	localparam int unsigned STALL_LIMIT = 5000;

	typedef struct packed {
		logic [7:0] data;
		logic       eob;
		logic       hold;
	} byte_item_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  frame_byte;
	logic        end_of_buffer;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  token_kind;
	logic [4:0]  field_code;
	logic [63:0] field_value;
	logic [1:0]  status_code;
	logic        is_last;

	byte_item_t pending_bytes[$];
	tok_t       expected_tokens[$];
	int         mismatch_count;
	int         idle_cycles;
	int         in_gap;
	int         out_gap;
	bit         quiet_tail;
	bit         stim_done;
	bit         hold_wait;

	// Accept flags from the last rising edge
	bit         in_ready_seen;

	// Parser state mirror
	logic [31:0] p_seen;
	logic [31:0] p_size;
	logic [7:0]  p_kind;
	logic [4:0]  p_step;
	logic [63:0] p_acc;
	logic [2:0]  p_bif;
	logic [31:0] p_left;
	logic [6:0]  p_walk;
	logic [1:0]  p_err;

	file_protocol_frame_parser DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.frame_byte(frame_byte),
		.end_of_buffer(end_of_buffer),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.token_kind(token_kind),
		.field_code(field_code),
		.field_value(field_value),
		.status_code(status_code),
		.is_last(is_last)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Field list per message type: {class, code}
	function automatic logic [7:0] field_op(input logic [7:0] k, input logic [4:0] s);
		logic [7:0] ops [0:7];
		int i;
		for (i = 0; i < 8; i++) ops[i] = 8'h00;
		case (k)
			8'd100, 8'd101: begin
				ops[0] = {CL_U32, 5'd2}; ops[1] = {CL_STR, 5'd3};
			end
			8'd104: begin
				ops[0] = {CL_U32, 5'd4}; ops[1] = {CL_U32, 5'd5};
				ops[2] = {CL_STR, 5'd6}; ops[3] = {CL_STR, 5'd7};
			end
			8'd105: begin
				ops[0] = {CL_U8, 5'd8}; ops[1] = {CL_U32, 5'd9}; ops[2] = {CL_U64, 5'd10};
			end
			8'd107: ops[0] = {CL_STR, 5'd11};
			8'd110: begin
				ops[0] = {CL_U32, 5'd4}; ops[1] = {CL_U32, 5'd12};
				ops[2] = {CL_U16, 5'd13}; ops[3] = {CL_STR, 5'd14};
			end
			8'd111: begin
				ops[0] = {CL_U16, 5'd15}; ops[1] = {CL_U8, 5'd8};
				ops[2] = {CL_U32, 5'd9}; ops[3] = {CL_U64, 5'd10};
			end
			8'd112: begin
				ops[0] = {CL_U32, 5'd4}; ops[1] = {CL_U8, 5'd16};
			end
			8'd113, 8'd115: begin
				ops[0] = {CL_U8, 5'd8}; ops[1] = {CL_U32, 5'd9};
				ops[2] = {CL_U64, 5'd10}; ops[3] = {CL_U32, 5'd17};
			end
			8'd114: begin
				ops[0] = {CL_U32, 5'd4}; ops[1] = {CL_STR, 5'd18};
				ops[2] = {CL_U32, 5'd19}; ops[3] = {CL_U8, 5'd16};
			end
			8'd118: begin
				ops[0] = {CL_U32, 5'd4}; ops[1] = {CL_U64, 5'd20}; ops[2] = {CL_D32, 5'd21};
			end
			8'd119: ops[0] = {CL_U32, 5'd21};
			8'd116: begin
				ops[0] = {CL_U32, 5'd4}; ops[1] = {CL_U64, 5'd20}; ops[2] = {CL_U32, 5'd21};
			end
			8'd117: ops[0] = {CL_D32, 5'd21};
			8'd125: ops[0] = {CL_D16, 5'd21};
			8'd120, 8'd122, 8'd124: ops[0] = {CL_U32, 5'd4};
			8'd108: ops[0] = {CL_U16, 5'd23};
			default: ;
		endcase
		if (s >= 5'd8) return 8'h00;
		return ops[s[2:0]];
	endfunction

	function automatic int width_of(input logic [2:0] cl);
		case (cl)
			CL_U8: return 1;
			CL_U16, CL_STR, CL_D16: return 2;
			CL_U64: return 8;
			default: return 4;
		endcase
	endfunction

	task automatic clear_parser();
		p_seen = '0; p_size = '0; p_kind = '0; p_step = '0; p_acc = '0;
		p_bif = '0; p_left = '0; p_walk = '0; p_err = '0;
	endtask

	task automatic push_token(input logic [1:0] k, input logic [4:0] c,
			input logic [63:0] v, input logic [1:0] st, input logic l);
		tok_t t;
		t.kind = k; t.code = c; t.value = v; t.status = st; t.last = l;
		expected_tokens.push_back(t);
	endtask

	// Step to next field, looping over walk names
	task automatic next_field();
		p_step = p_step + 5'd1;
		if (field_op(p_kind, p_step) == 8'h00 && p_walk > 0) begin
			p_walk = p_walk - 7'd1;
			if (p_walk > 0) p_step = (p_kind == KIND_TWALK) ? 5'd3 : 5'd1;
		end
	endtask

	task automatic parse_body(input logic [7:0] b, input logic [31:0] pos);
		logic [7:0]  op;
		logic [2:0]  cl;
		logic [4:0]  code;
		logic [63:0] v;
		logic [31:0] room;
		op = field_op(p_kind, p_step);
		cl = op[7:5];
		code = op[4:0];
		if (p_left > 0) begin
			if (cl == CL_STR) push_token(TK_STR, code, {56'd0, b}, ST_OK, 1'b0);
			else push_token(TK_DATA, CODE_DATA, {56'd0, b}, ST_OK, 1'b0);
			p_left = p_left - 32'd1;
			if (p_left == 0) next_field();
			return;
		end
		if (op == 8'h00) return;
		p_acc = p_acc | ({56'd0, b} << (8 * p_bif));
		if (int'(p_bif) + 1 < width_of(cl)) begin
			p_bif = p_bif + 3'd1;
			return;
		end
		v = p_acc;
		p_acc = '0;
		p_bif = '0;
		push_token(TK_NUM, code, v, ST_OK, 1'b0);
		room = p_size - pos - 32'd1;
		if (cl == CL_STR || cl == CL_D32 || cl == CL_D16) begin
			if (v > {32'd0, room}) p_err = ST_PAST_END;
			else if (v == 0) next_field();
			else p_left = v[31:0];
		end else if (code == CODE_NWNAME || code == CODE_NWQID) begin
			if (v > 64'(WALK_LIMIT)) p_err = ST_WALK_LONG;
			else if (v == 0) begin
				while (p_step < 5'd8 && field_op(p_kind, p_step) != 8'h00) p_step = p_step + 5'd1;
			end else begin
				p_walk = v[6:0];
				p_step = p_step + 5'd1;
			end
		end else begin
			next_field();
		end
	endtask

	// Predict tokens for one accepted word
	task automatic predict_tokens(input logic [7:0] b, input logic eob);
		logic [31:0] pos;
		logic [1:0]  st;
		pos = p_seen;
		if (pos != 32'hFFFF_FFFF) p_seen = pos + 32'd1;
		if (pos < 4) begin
			p_size = p_size | ({24'd0, b} << (8 * pos));
		end else if (p_err == ST_OK && p_size >= MIN_FRAME && pos < p_size) begin
			if (pos == 4) begin
				p_kind = b;
				push_token(TK_NUM, CODE_TYPE, {56'd0, b}, ST_OK, 1'b0);
			end else if (pos == 5) begin
				p_acc = {56'd0, b};
			end else if (pos == 6) begin
				push_token(TK_NUM, CODE_TAG, p_acc | ({56'd0, b} << 8), ST_OK, 1'b0);
				p_acc = '0;
			end else begin
				parse_body(b, pos);
			end
		end
		if (eob) begin
			if (p_seen < MIN_FRAME || p_size < MIN_FRAME || p_size > p_seen) st = ST_BAD_SIZE;
			else if (p_err != ST_OK) st = p_err;
			else if (field_op(p_kind, p_step) != 8'h00) st = ST_PAST_END;
			else st = ST_OK;
			push_token(TK_STATUS, 5'd0, 64'd0, st, 1'b1);
			clear_parser();
		end
	endtask

	// Frame builders
	logic [7:0] body_buf[$];

	task automatic add_le(input logic [63:0] v, input int n);
		int i;
		for (i = 0; i < n; i++) body_buf.push_back(v[8*i +: 8]);
	endtask

	task automatic add_text(input int n, input bit as_len);
		int i;
		if (as_len) add_le(64'(n), 2);
		for (i = 0; i < n; i++) body_buf.push_back(8'($urandom_range(0, 255)));
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// Build a well-formed body for the given type; unknown types get random filler
	task automatic fill_body(input logic [7:0] k);
		int n;
		int i;
		case (k)
			8'd100, 8'd101: begin
				add_le(64'($urandom()), 4); add_text($urandom_range(0, 6), 1);
			end
			8'd104: begin
				add_le(64'($urandom()), 4); add_le(64'($urandom()), 4);
				add_text($urandom_range(0, 5), 1); add_text($urandom_range(0, 5), 1);
			end
			8'd105: begin
				add_le(64'($urandom()), 1); add_le(64'($urandom()), 4); add_le(rand64(), 8);
			end
			8'd107: add_text($urandom_range(0, 8), 1);
			8'd110: begin
				n = ($urandom_range(0, 9) == 0) ? WALK_LIMIT : $urandom_range(0, 3);
				add_le(64'($urandom()), 4); add_le(64'($urandom()), 4); add_le(64'(n), 2);
				for (i = 0; i < n; i++) add_text($urandom_range(0, 3), 1);
			end
			8'd111: begin
				n = $urandom_range(0, 3);
				add_le(64'(n), 2);
				for (i = 0; i < n; i++) begin
					add_le(64'($urandom()), 1); add_le(64'($urandom()), 4); add_le(rand64(), 8);
				end
			end
			8'd112: begin add_le(64'($urandom()), 4); add_le(64'($urandom()), 1); end
			8'd113, 8'd115: begin
				add_le(64'($urandom()), 1); add_le(64'($urandom()), 4);
				add_le(rand64(), 8); add_le(64'($urandom()), 4);
			end
			8'd114: begin
				add_le(64'($urandom()), 4); add_text($urandom_range(0, 5), 1);
				add_le(64'($urandom()), 4); add_le(64'($urandom()), 1);
			end
			8'd118: begin
				add_le(64'($urandom()), 4); add_le(rand64(), 8);
				n = $urandom_range(0, 6); add_le(64'(n), 4); add_text(n, 0);
			end
			8'd119, 8'd120, 8'd122, 8'd124: add_le(64'($urandom()), 4);
			8'd116: begin
				add_le(64'($urandom()), 4); add_le(rand64(), 8); add_le(64'($urandom()), 4);
			end
			8'd117: begin n = $urandom_range(0, 6); add_le(64'(n), 4); add_text(n, 0); end
			8'd125: begin n = $urandom_range(0, 6); add_le(64'(n), 2); add_text(n, 0); end
			8'd108: add_le(64'($urandom()), 2);
			default: add_text($urandom_range(0, 4), 0);
		endcase
	endtask

	// Queue a frame: size header, type, tag, body, extra; size may be adjusted and the tail cut
	task automatic queue_frame(input logic [7:0] k, input logic [15:0] tag,
			input int size_adj, input int cut, input int extra, input bit pause_after);
		byte_item_t it;
		logic [31:0] sz;
		int total;
		int i;
		logic [7:0] all_bytes[$];
		body_buf.delete();
		fill_body(k);
		sz = 32'(7 + body_buf.size() + size_adj);
		for (i = 0; i < 4; i++) all_bytes.push_back(sz[8*i +: 8]);
		all_bytes.push_back(k);
		all_bytes.push_back(tag[7:0]);
		all_bytes.push_back(tag[15:8]);
		foreach (body_buf[j]) all_bytes.push_back(body_buf[j]);
		for (i = 0; i < extra; i++) all_bytes.push_back(8'($urandom_range(0, 255)));
		total = all_bytes.size() - cut;
		if (total < 1) total = 1;
		for (i = 0; i < total; i++) begin
			it.data = all_bytes[i];
			it.eob = (i == total - 1);
			it.hold = pause_after && (i == total - 1);
			pending_bytes.push_back(it);
		end
	endtask

	// Queue raw bytes as one frame
	task automatic queue_raw(input logic [7:0] raw[$]);
		byte_item_t it;
		foreach (raw[i]) begin
			it.data = raw[i];
			it.eob = (i == raw.size() - 1);
			it.hold = 1'b0;
			pending_bytes.push_back(it);
		end
	endtask

	function automatic logic [7:0] pick_kind();
		logic [7:0] kinds[] = '{8'd100, 8'd101, 8'd104, 8'd105, 8'd107, 8'd108, 8'd110,
			8'd111, 8'd112, 8'd113, 8'd114, 8'd115, 8'd116, 8'd117, 8'd118, 8'd119,
			8'd120, 8'd122, 8'd124, 8'd125};
		return kinds[$urandom_range(0, kinds.size() - 1)];
	endfunction

	// Fill stimulus
	initial begin
		logic [7:0] raw[$];
		logic [7:0] kinds[] = '{8'd100, 8'd104, 8'd105, 8'd107, 8'd108, 8'd110, 8'd111,
			8'd112, 8'd113, 8'd114, 8'd116, 8'd117, 8'd118, 8'd119, 8'd120, 8'd125};
		int r;
		// Directed: one type from each known program row
		foreach (kinds[i]) queue_frame(kinds[i], 16'hFFFF, 0, 0, 0, i == 3);
		// Unknown type, trailing bytes past size, size too small, short frame
		queue_frame(8'd0, 16'h0000, 0, 0, 3, 1'b0);
		queue_frame(8'd255, 16'h1234, 0, 0, 0, 1'b0);
		raw = '{8'd6, 8'd0, 8'd0, 8'd0, 8'd100, 8'd1, 8'd2, 8'd3};
		queue_raw(raw);
		raw = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'd100};
		queue_raw(raw);
		queue_frame(8'd108, 16'h0102, 5, 0, 0, 1'b0);
		// Window ends inside a field
		queue_frame(8'd105, 16'h0001, -3, 0, 3, 1'b0);
		// String longer than window
		raw = '{8'd10, 8'd0, 8'd0, 8'd0, 8'd107, 8'd0, 8'd0, 8'd9, 8'd0, 8'd65};
		queue_raw(raw);
		// Walk count too long
		raw = '{8'd17, 8'd0, 8'd0, 8'd0, 8'd110, 8'd0, 8'd0, 8'd1, 8'd2, 8'd3, 8'd4,
			8'd5, 8'd6, 8'd7, 8'd8, 8'(WALK_LIMIT + 1), 8'd0};
		queue_raw(raw);
		// Random frames: mostly well-formed, some broken
		while (pending_bytes.size() < 1000) begin
			r = $urandom_range(0, 19);
			if (r < 14) begin
				queue_frame(pick_kind(), 16'($urandom()), 0, 0, 0, 1'b0);
			end else if (r == 14) begin
				queue_frame(pick_kind(), 16'($urandom()), 0, 0, $urandom_range(1, 4), 1'b0);
			end else if (r == 15) begin
				queue_frame(pick_kind(), 16'($urandom()), 0, $urandom_range(1, 6), 0, 1'b0);
			end else if (r == 16) begin
				queue_frame(pick_kind(), 16'($urandom()), -int'($urandom_range(1, 5)), 0, 0,
					1'b0);
			end else if (r == 17) begin
				queue_frame(8'($urandom()), 16'($urandom()), 0, 0, 0, 1'b0);
			end else begin
				raw.delete();
				repeat ($urandom_range(1, 20)) raw.push_back(8'($urandom_range(0, 255)));
				queue_raw(raw);
			end
		end
	end

	// Reset
	initial begin
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// Driver: change inputs at the falling edge
	initial begin
		in_valid = 1'b0;
		frame_byte = '0;
		end_of_buffer = 1'b0;
		out_ready = 1'b0;
		in_gap = 0;
		out_gap = 0;
		quiet_tail = 1'b0;
		stim_done = 1'b0;
		hold_wait = 1'b0;
		mismatch_count = 0;
		idle_cycles = 0;
		clear_parser();
	end

	always @(negedge clk) begin
		if (arst_n) begin
			quiet_tail <= (pending_bytes.size() < 100);
			// Advance sender
			if (!in_valid || in_ready_seen) begin
				if (hold_wait && expected_tokens.size() != 0) begin
					in_valid <= 1'b0;
				end else if (in_gap > 0) begin
					in_gap <= in_gap - 1;
					in_valid <= 1'b0;
				end else if (pending_bytes.size() != 0) begin
					if (!quiet_tail && $urandom_range(0, 7) == 0) begin
						in_gap <= $urandom_range(0, 3);
						in_valid <= 1'b0;
					end else begin
						hold_wait <= pending_bytes[0].hold;
						frame_byte <= pending_bytes[0].data;
						end_of_buffer <= pending_bytes[0].eob;
						in_valid <= 1'b1;
						void'(pending_bytes.pop_front());
					end
				end else begin
					in_valid <= 1'b0;
					stim_done <= 1'b1;
				end
			end
			// Receiver stalls
			if (out_gap > 0) begin
				out_gap <= out_gap - 1;
				out_ready <= 1'b0;
			end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
				out_gap <= $urandom_range(0, 3);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Monitor: sample at the rising edge
	always @(posedge clk) begin
		tok_t want;
		in_ready_seen <= in_valid && in_ready;
		if (arst_n) begin
			if (in_valid && in_ready) predict_tokens(frame_byte, end_of_buffer);
			if (out_valid && out_ready) begin
				if (expected_tokens.size() == 0) begin
					mismatch_count = mismatch_count + 1;
					if (mismatch_count <= 10)
						$display("unexpected token kind=%0d code=%0d value=%h status=%0d last=%0b",
							token_kind, field_code, field_value, status_code, is_last);
				end else begin
					want = expected_tokens.pop_front();
					if (want.kind !== token_kind || want.code !== field_code ||
							want.value !== field_value || want.status !== status_code ||
							want.last !== is_last) begin
						mismatch_count = mismatch_count + 1;
						if (mismatch_count <= 10)
							$display("token mismatch: exp %0d/%0d/%h/%0d/%0b got %0d/%0d/%h/%0d/%0b",
								want.kind, want.code, want.value, want.status, want.last,
								token_kind, field_code, field_value, status_code, is_last);
					end
				end
			end
			if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
			else idle_cycles = idle_cycles + 1;
		end
	end

	// Finish or watchdog
	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (idle_cycles >= STALL_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end
			if (stim_done && !in_valid && expected_tokens.size() == 0) begin
				repeat (20) @(posedge clk);
				if (mismatch_count == 0 && expected_tokens.size() == 0) begin
					$display("ALL CHECKS PASSED");
				end else begin
					$display("CHECKS FAILED");
				end
				$finish;
			end
		end
	end

endmodule

// ----- filelist.f -----
src/fpp_pkg.sv
src/fpp_tok_fifo.sv
src/file_protocol_frame_parser.sv
tb/sv/file_protocol_frame_parser_tb.sv
